[rtl/core/brb_pkg.sv]
// shared types and constants of the burst byte ring buffer
package brb_pkg;

  // slot count must be a power of two and a multiple of the lane count
  localparam int SLOTS  = 1024;
  localparam int LANES  = 8;
  localparam int PTR_W  = $clog2(SLOTS);
  localparam int LANE_W = $clog2(LANES);
  localparam int ROW_W  = PTR_W - LANE_W;
  localparam int ROWS   = SLOTS / LANES;
  localparam int CNT_W  = 4;
  localparam int FILL_W = 10;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e                       kind;
    logic [PTR_W-1:0]            base;
    logic [CNT_W-1:0]            done;
    logic [LANES-1:0][7:0]       data;
    logic [FILL_W-1:0]           fill;
  } cmd_t;

endpackage

[rtl/core/brb_ram.sv]
// one byte bank: single address port, registered read data
module brb_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/brb_front.sv]
// front end: owns the positions, clamps each request and builds a command
module brb_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [1:0]                         func_i,
  input  logic [brb_pkg::CNT_W-1:0]          count_i,
  input  logic [brb_pkg::LANES-1:0][7:0]     data_i,
  output brb_pkg::cmd_t                      cmd_o
);
  import brb_pkg::*;

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PTR_W-1:0] used, room, level;
  logic [CNT_W-1:0] req, done;
  kind_e            kind;

  always_comb begin
    used = wp_q - rp_q;
    room = PTR_W'(SLOTS - 1) - used;
    req  = (count_i > CNT_W'(LANES)) ? CNT_W'(LANES) : count_i;
    done = '0;
    kind = KIND_NONE;
    wp_d = wp_q;
    rp_d = rp_q;
    level = used;
    case (func_i)
      FUNC_WRITE: begin
        kind  = KIND_WRITE;
        done  = (PTR_W'(req) < room) ? req : CNT_W'(room);
        wp_d  = wp_q + PTR_W'(done);
        level = used + PTR_W'(done);
      end
      FUNC_READ: begin
        kind  = KIND_READ;
        done  = (PTR_W'(req) < used) ? req : CNT_W'(used);
        rp_d  = rp_q + PTR_W'(done);
        level = used - PTR_W'(done);
      end
      FUNC_PEEK: begin
        kind = KIND_READ;
        done = (PTR_W'(req) < used) ? req : CNT_W'(used);
      end
      default: begin
        kind = KIND_NONE;
      end
    endcase
    cmd_o.kind = kind;
    cmd_o.base = (kind == KIND_WRITE) ? wp_q : rp_q;
    cmd_o.done = done;
    cmd_o.data = data_i;
    cmd_o.fill = FILL_W'(level);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else if (accept_i) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

[rtl/core/brb_queue.sv]
// short command queue between front and back
module brb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  brb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output brb_pkg::cmd_t cmd_o
);
  import brb_pkg::*;

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_d    = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d    = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d   = cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
  end

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

[rtl/core/brb_back.sv]
// back end: eight byte banks, one command a cycle, result in the cycle after
module brb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  brb_pkg::cmd_t                  cmd_i,
  output logic                           res_valid_o,
  output logic [brb_pkg::CNT_W-1:0]      done_count_o,
  output logic [brb_pkg::LANES-1:0][7:0] out_bytes_o,
  output logic [brb_pkg::FILL_W-1:0]     fill_level_o
);
  import brb_pkg::*;

  logic [ROW_W-1:0]      base_row;
  logic [LANE_W-1:0]     base_bank;
  logic [LANES-1:0][7:0] bank_rdata;

  logic                  res_valid_q;
  logic                  res_read_q;
  logic [LANE_W-1:0]     res_bank_q;
  logic [CNT_W-1:0]      res_done_q;
  logic [FILL_W-1:0]     res_fill_q;

  assign base_row  = cmd_i.base[PTR_W-1:LANE_W];
  assign base_bank = cmd_i.base[LANE_W-1:0];

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    localparam logic [LANE_W-1:0] BANK = LANE_W'(b);
    logic [LANE_W-1:0] lane;
    logic [ROW_W-1:0]  row;
    logic              we;

    always_comb begin
      // banks below the start bank hold the bytes that spill into the next row
      lane = BANK - base_bank;
      row  = base_row + ROW_W'(BANK < base_bank);
      we   = cmd_valid_i && (cmd_i.kind == KIND_WRITE) && (CNT_W'(lane) < cmd_i.done);
    end

    brb_ram #(
      .DEPTH (ROWS),
      .WIDTH (8)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .addr_i  (row),
      .wdata_i (cmd_i.data[lane]),
      .rdata_o (bank_rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      res_read_q <= (cmd_i.kind == KIND_READ);
      res_bank_q <= base_bank;
      res_done_q <= cmd_i.done;
      res_fill_q <= cmd_i.fill;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_bytes_o[l] = (res_read_q && (CNT_W'(l) < res_done_q))
                       ? bank_rdata[res_bank_q + LANE_W'(l)] : 8'h00;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign done_count_o = res_done_q;
  assign fill_level_o = res_fill_q;

  a_result_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |=> res_valid_o)
    else $error("command taken without a result beat");

  a_done_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (done_count_o <= CNT_W'(LANES)))
    else $error("done count beyond lane count");

  a_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_read_q) |-> (out_bytes_o == '0))
    else $error("read data on a non-read beat");

endmodule

[rtl/core/byte_ring_buffer_burst.sv]
// top level of the burst byte ring buffer
//
// a ring of 1024 byte slots, one always left empty, so up to 1023 bytes held.
// command channel: a beat is taken at a rising edge with start_i high and
// busy_o low. func_i selects write, read (consumes) or peek; count_i asks for
// up to 8 bytes, larger counts act as 8, in_byte0_i first.
// result channel: res_valid_o is high for exactly one cycle per command, after
// the queue slot and the bank read register, with done_count_o (bytes
// written or read after clamping to free or stored space), out_byte0_o..7
// (zero past done_count_o and on writes) and fill_level_o after the command.
// the front end updates both positions in the accepting cycle and drops the
// command into a two-entry queue; the back end drains one command a cycle
// into eight byte banks, so one burst is taken every cycle and busy_o only
// rises if the queue were ever full. a command is registered in the queue and
// again in the banks' registered read port.
// the receiver cannot stall: every result beat is shown once.
// reset clears both positions and the queue; the byte store is not cleared.
module byte_ring_buffer_burst (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  count_i,
  input  logic [7:0]  in_byte0_i,
  input  logic [7:0]  in_byte1_i,
  input  logic [7:0]  in_byte2_i,
  input  logic [7:0]  in_byte3_i,
  input  logic [7:0]  in_byte4_i,
  input  logic [7:0]  in_byte5_i,
  input  logic [7:0]  in_byte6_i,
  input  logic [7:0]  in_byte7_i,
  output logic        res_valid_o,
  output logic [3:0]  done_count_o,
  output logic [7:0]  out_byte0_o,
  output logic [7:0]  out_byte1_o,
  output logic [7:0]  out_byte2_o,
  output logic [7:0]  out_byte3_o,
  output logic [7:0]  out_byte4_o,
  output logic [7:0]  out_byte5_o,
  output logic [7:0]  out_byte6_o,
  output logic [7:0]  out_byte7_o,
  output logic [9:0]  fill_level_o
);
  import brb_pkg::*;

  logic                  accept;
  logic                  q_full, q_valid;
  cmd_t                  front_cmd, back_cmd;
  logic [LANES-1:0][7:0] in_bytes, out_bytes;

  assign in_bytes = {in_byte7_i, in_byte6_i, in_byte5_i, in_byte4_i,
                     in_byte3_i, in_byte2_i, in_byte1_i, in_byte0_i};
  assign busy_o   = q_full;
  assign accept   = start_i && !q_full;

  brb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (func_i),
    .count_i  (count_i),
    .data_i   (in_bytes),
    .cmd_o    (front_cmd)
  );

  brb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (1'b1),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  brb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (back_cmd),
    .res_valid_o  (res_valid_o),
    .done_count_o (done_count_o),
    .out_bytes_o  (out_bytes),
    .fill_level_o (fill_level_o)
  );

  assign out_byte0_o = out_bytes[0];
  assign out_byte1_o = out_bytes[1];
  assign out_byte2_o = out_bytes[2];
  assign out_byte3_o = out_bytes[3];
  assign out_byte4_o = out_bytes[4];
  assign out_byte5_o = out_bytes[5];
  assign out_byte6_o = out_bytes[6];
  assign out_byte7_o = out_bytes[7];

endmodule

[tb/tb_top.sv]
// self-checking testbench for the burst byte ring buffer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  localparam int RANDOM_BURSTS = 1250;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_FILL      = SLOTS - 1;

  typedef struct packed {
    func_e                 func;
    logic [CNT_W-1:0]      count;
    logic [LANES-1:0][7:0] data;
  } burst_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]      done;
    logic [LANES-1:0][7:0] data;
    logic [FILL_W-1:0]     fill;
  } burst_res_t;

  // mirror of the ring: predicts each result beat and checks it in order
  class fifo_mirror;
    logic [7:0]       store [SLOTS];
    logic [PTR_W-1:0] wr_pos;
    logic [PTR_W-1:0] rd_pos;
    burst_res_t       expected_bursts[$];
    int errors, beats_checked;
    int n_write, n_read, n_peek, n_none, n_clamped, n_short, n_wraps, peak_fill;

    function new();
      wr_pos = '0;
      rd_pos = '0;
    endfunction

    function int level();
      logic [PTR_W-1:0] diff;
      diff = wr_pos - rd_pos;
      return int'(diff);
    endfunction

    function int pending();
      return expected_bursts.size();
    endfunction

    function void note_command(burst_cmd_t c);
      burst_res_t r;
      int req, used, room, done, lane;
      used = level();
      room = MAX_FILL - used;
      req  = (c.count > LANES) ? LANES : int'(c.count);
      r    = '0;
      done = 0;
      case (c.func)
        FUNC_WRITE: begin
          n_write++;
          done = (req < room) ? req : room;
          if (req > room) n_clamped++;
          for (lane = 0; lane < done; lane++)
            store[(int'(wr_pos) + lane) % SLOTS] = c.data[lane];
          if (int'(wr_pos) + done >= SLOTS) n_wraps++;
          wr_pos = PTR_W'((int'(wr_pos) + done) % SLOTS);
        end
        FUNC_READ, FUNC_PEEK: begin
          if (c.func == FUNC_READ) n_read++;
          else n_peek++;
          done = (req < used) ? req : used;
          if (req > used) n_short++;
          for (lane = 0; lane < done; lane++)
            r.data[lane] = store[(int'(rd_pos) + lane) % SLOTS];
          if (c.func == FUNC_READ)
            rd_pos = PTR_W'((int'(rd_pos) + done) % SLOTS);
        end
        default: n_none++;
      endcase
      r.done = CNT_W'(done);
      r.fill = FILL_W'(level());
      if (level() > peak_fill) peak_fill = level();
      expected_bursts.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_result(burst_res_t got);
      burst_res_t want;
      int lane;
      if (expected_bursts.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = expected_bursts.pop_front();
      beats_checked++;
      if (got.done !== want.done)
        report($sformatf("beat %0d done_count %0d, want %0d",
                         beats_checked, got.done, want.done));
      for (lane = 0; lane < LANES; lane++)
        if (got.data[lane] !== want.data[lane])
          report($sformatf("beat %0d out_byte%0d 0x%02h, want 0x%02h",
                           beats_checked, lane, got.data[lane], want.data[lane]));
      if (got.fill !== want.fill)
        report($sformatf("beat %0d fill_level %0d, want %0d",
                         beats_checked, got.fill, want.fill));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic       res_valid_o;
  logic [3:0] done_count_o;
  logic [7:0] out_byte0_o, out_byte1_o, out_byte2_o, out_byte3_o;
  logic [7:0] out_byte4_o, out_byte5_o, out_byte6_o, out_byte7_o;
  logic [9:0] fill_level_o;

  burst_cmd_t beat_cmd;
  fifo_mirror sb = new();
  bit         idle_on;
  int         cycles;

  byte_ring_buffer_burst u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (beat_cmd.func),
    .count_i      (beat_cmd.count),
    .in_byte0_i   (beat_cmd.data[0]),
    .in_byte1_i   (beat_cmd.data[1]),
    .in_byte2_i   (beat_cmd.data[2]),
    .in_byte3_i   (beat_cmd.data[3]),
    .in_byte4_i   (beat_cmd.data[4]),
    .in_byte5_i   (beat_cmd.data[5]),
    .in_byte6_i   (beat_cmd.data[6]),
    .in_byte7_i   (beat_cmd.data[7]),
    .res_valid_o  (res_valid_o),
    .done_count_o (done_count_o),
    .out_byte0_o  (out_byte0_o),
    .out_byte1_o  (out_byte1_o),
    .out_byte2_o  (out_byte2_o),
    .out_byte3_o  (out_byte3_o),
    .out_byte4_o  (out_byte4_o),
    .out_byte5_o  (out_byte5_o),
    .out_byte6_o  (out_byte6_o),
    .out_byte7_o  (out_byte7_o),
    .fill_level_o (fill_level_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // results first, then the command taken at this edge
  always @(posedge clk_i) begin
    burst_res_t got;
    if (rst_ni && res_valid_o) begin
      got.done    = done_count_o;
      got.data[0] = out_byte0_o;
      got.data[1] = out_byte1_o;
      got.data[2] = out_byte2_o;
      got.data[3] = out_byte3_o;
      got.data[4] = out_byte4_o;
      got.data[5] = out_byte5_o;
      got.data[6] = out_byte6_o;
      got.data[7] = out_byte7_o;
      got.fill    = fill_level_o;
      sb.check_result(got);
    end
    if (rst_ni && start_i && !busy_o) sb.note_command(beat_cmd);
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task drive_beat(burst_cmd_t c);
    while (idle_on && $urandom_range(99) < 15) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i  = 1'b1;
    beat_cmd = c;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task send(func_e f, int cnt, logic [63:0] bytes);
    burst_cmd_t c;
    c.func  = f;
    c.count = CNT_W'(cnt);
    c.data  = bytes;
    drive_beat(c);
  endtask

  task wait_drained();
    start_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic burst_cmd_t random_burst(bit filling);
    burst_cmd_t c;
    int r, lane;
    r = $urandom_range(99);
    if (filling)
      c.func = (r < 70) ? FUNC_WRITE : (r < 85) ? FUNC_READ :
               (r < 97) ? FUNC_PEEK : FUNC_NONE;
    else
      c.func = (r < 15) ? FUNC_WRITE : (r < 80) ? FUNC_READ :
               (r < 97) ? FUNC_PEEK : FUNC_NONE;
    // oversized counts now and then
    if ($urandom_range(9) == 0) c.count = CNT_W'($urandom_range(15, 9));
    else c.count = CNT_W'($urandom_range(8));
    for (lane = 0; lane < LANES; lane++) c.data[lane] = 8'($urandom);
    return c;
  endfunction

  initial begin
    bit filling;
    int n, linger, lvl;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    beat_cmd = '0;
    idle_on  = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty ring, extremes, oversized counts, unknown op
    send(FUNC_PEEK,  8, 64'h0);
    send(FUNC_READ,  4, 64'h0);
    send(FUNC_WRITE, 0, 64'hffff_ffff_ffff_ffff);
    send(FUNC_WRITE, 8, 64'hffff_ffff_ffff_ffff);
    send(FUNC_WRITE, 8, 64'h0);
    send(FUNC_WRITE, 15, 64'h5aa5_5aa5_a55a_a55a);
    send(FUNC_PEEK,  15, 64'h0);
    send(FUNC_READ,  3, 64'hffff_ffff_ffff_ffff);
    send(FUNC_NONE,  8, 64'h1234_5678_9abc_def0);
    send(FUNC_PEEK,  0, 64'h0);
    send(FUNC_READ,  8, 64'h0);
    send(FUNC_WRITE, 5, 64'h8040_2010_0804_0201);
    send(FUNC_READ,  12, 64'h0);
    send(FUNC_READ,  15, 64'h0);
    send(FUNC_NONE,  15, 64'hffff_ffff_ffff_ffff);
    send(FUNC_WRITE, 9, 64'hfedc_ba98_7654_3210);
    send(FUNC_PEEK,  10, 64'h0);
    send(FUNC_READ,  13, 64'h0);
    send(FUNC_READ,  1, 64'h0);
    wait_drained();

    // random: fill towards full, linger there, drain towards empty, linger, repeat
    filling = 1'b1;
    linger  = 0;
    for (n = 0; n < RANDOM_BURSTS; n++) begin
      lvl = sb.level();
      if (linger > 0) begin
        linger--;
        if (linger == 0) filling = !filling;
      end else if ((filling && lvl == MAX_FILL) || (!filling && lvl == 0)) begin
        linger = $urandom_range(30, 10);
      end
      idle_on = !(n >= 300 && n < 600);
      if (n == 700) wait_drained();
      drive_beat(random_burst(filling));
    end
    start_i = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (sb.pending() != 0) sb.report("expected beats left over at the end");
    $display("covered %0d writes (%0d clamped at full), %0d reads, %0d peeks, %0d unknown ops",
             sb.n_write, sb.n_clamped, sb.n_read, sb.n_peek, sb.n_none);
    $display("short returns %0d, peak fill %0d, write wraps %0d, beats checked %0d",
             sb.n_short, sb.peak_fill, sb.n_wraps, sb.beats_checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
